FILE: sv/m65_pkg.sv
`timescale 1ns / 1ps
package m65_pkg;
    localparam int QueueDepth = 2;

    localparam logic [5:0] F_ADC = 6'd0,  F_AND = 6'd1,  F_ASL = 6'd2,  F_BCC = 6'd3;
    localparam logic [5:0] F_BCS = 6'd4,  F_BEQ = 6'd5,  F_BIT = 6'd6,  F_BMI = 6'd7;
    localparam logic [5:0] F_BNE = 6'd8,  F_BPL = 6'd9,  F_BRK = 6'd10, F_BVC = 6'd11;
    localparam logic [5:0] F_BVS = 6'd12, F_CLC = 6'd13, F_CLD = 6'd14, F_CLI = 6'd15;
    localparam logic [5:0] F_CLV = 6'd16, F_CMP = 6'd17, F_CPX = 6'd18, F_CPY = 6'd19;
    localparam logic [5:0] F_DEC = 6'd20, F_DEX = 6'd21, F_DEY = 6'd22, F_EOR = 6'd23;
    localparam logic [5:0] F_INC = 6'd24, F_INX = 6'd25, F_INY = 6'd26, F_JMP = 6'd27;
    localparam logic [5:0] F_JSR = 6'd28, F_LDA = 6'd29, F_LDX = 6'd30, F_LDY = 6'd31;
    localparam logic [5:0] F_LSR = 6'd32, F_ORA = 6'd34, F_PHA = 6'd35;
    localparam logic [5:0] F_PHP = 6'd36, F_PLA = 6'd37, F_PLP = 6'd38, F_ROL = 6'd39;
    localparam logic [5:0] F_ROR = 6'd40, F_RTI = 6'd41, F_RTS = 6'd42, F_SBC = 6'd43;
    localparam logic [5:0] F_SEC = 6'd44, F_SED = 6'd45, F_SEI = 6'd46, F_STA = 6'd47;
    localparam logic [5:0] F_STX = 6'd48, F_STY = 6'd49, F_TAX = 6'd50, F_TAY = 6'd51;
    localparam logic [5:0] F_TSX = 6'd52, F_TXA = 6'd53, F_TXS = 6'd54, F_TYA = 6'd55;

    localparam logic [7:0] P_RESET  = 8'h24;
    localparam logic [7:0] SP_RESET = 8'hFD;

    // Decoded instruction held in the queue
    typedef struct packed {
        logic [5:0]  func;
        logic        on_acc;
        logic [7:0]  m;
        logic [15:0] ea;
        logic [15:0] npc;
        logic [15:0] target;   // branch target, precomputed
        logic [7:0]  s1;
        logic [7:0]  s2;
        logic [7:0]  s3;
        logic [1:0]  nwr;      // write count minus one (0 also for no write)
    } m65_op_t;

    typedef struct packed {
        logic        mem_write;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [15:0] new_pc;
        logic [7:0]  flags_out;
        logic        last;
    } m65_res_t;
endpackage

FILE: sv/mos6502_execute_unit.sv
`timescale 1ns / 1ps
// Channel | Dir | Handshake          | Payload
// s_      | in  | s_tvalid/s_tready  | s_tdata: one decoded instruction
// m_      | out | m_tvalid/m_tready  | m_tdata: write and pc/flags, m_tlast
//
// One item per cycle for ops with zero or one write, when not stalled; JSR
// and BRK hold the input while the back-end stack-push sequencer writes.
// Front end: classifies and queues items in a small FIFO; back end holds
// A/X/Y/SP/P and an output register. Synchronous active-low reset puts
// SP=FD, P=24, A/X/Y zero. Either side may stall independently.
module mos6502_execute_unit #(
    parameter int QDepth = m65_pkg::QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[5:0] on_accumulator[6] operand_byte[14:7] effective_address[30:15]
    // next_pc[46:31] stack_byte1[54:47] stack_byte2[62:55] stack_byte3[70:63]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // mem_write[0] write_address[16:1] write_data[24:17] new_pc[40:25]
    // flags_out[48:41]
    output logic [55:0] m_tdata,
    output logic        m_tlast
);
    import m65_pkg::*;

    logic       q_valid, q_ready;
    m65_op_t    q_op;
    m65_res_t   res;

    m65_front #(.Depth(QDepth)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata[70:0]),
        .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op)
    );

    m65_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {7'd0, res.flags_out, res.new_pc, res.write_data,
                      res.write_address, res.mem_write};
    assign m_tlast = res.last;
endmodule

FILE: sv/m65_front.sv
`timescale 1ns / 1ps
module m65_front #(
    parameter int Depth = m65_pkg::QueueDepth
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [70:0]          in_data,
    output logic                 q_valid,
    input  logic                 q_ready,
    output m65_pkg::m65_op_t     q_op
);
    import m65_pkg::*;
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    m65_op_t op_w;
    m65_op_t mem_reg [Depth];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic push, pop;

    always_comb begin
        op_w.func   = in_data[5:0];
        op_w.on_acc = in_data[6];
        op_w.m      = in_data[14:7];
        op_w.ea     = in_data[30:15];
        op_w.npc    = in_data[46:31];
        op_w.s1     = in_data[54:47];
        op_w.s2     = in_data[62:55];
        op_w.s3     = in_data[70:63];
        op_w.target = in_data[46:31] + {{8{in_data[14]}}, in_data[14:7]};
        case (in_data[5:0])
            F_BRK:   op_w.nwr = 2'd2;
            F_JSR:   op_w.nwr = 2'd1;
            default: op_w.nwr = 2'd0;
        endcase
    end

    assign in_ready = (cnt_reg != (AW+1)'(Depth));
    assign q_valid  = (cnt_reg != '0);
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;
    assign q_op = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= op_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= (wp_reg == AW'(Depth-1)) ? '0 : wp_reg + 1'b1;
            if (pop)  rp_reg <= (rp_reg == AW'(Depth-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

FILE: sv/m65_back.sv
`timescale 1ns / 1ps
module m65_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  m65_pkg::m65_op_t     q_op,
    output logic                 out_valid,
    input  logic                 out_ready,
    output m65_pkg::m65_res_t    out_res
);
    import m65_pkg::*;

    logic [7:0] a_reg, x_reg, y_reg, sp_reg, p_reg;
    logic [7:0] a_next, x_next, y_next, sp_next, p_next;
    logic [1:0] k_reg;              // write index within a multi-write op
    logic       ov_reg;
    m65_res_t   ov_res_reg;

    // pending writes after the first for JSR/BRK
    logic [7:0] wd1_reg, wd2_reg;
    logic [15:0] pc_hold_reg;
    logic [7:0]  p_hold_reg;

    logic        can_out, busy;
    m65_res_t    r0;
    logic [7:0]  v, rr, wd1, wd2;
    logic [8:0]  sum;
    logic [7:0]  am;
    logic        ci;

    assign can_out = !ov_reg || out_ready;
    assign busy    = (k_reg != 2'd0);
    assign q_ready = can_out && !busy;
    assign out_valid = ov_reg;
    assign out_res   = ov_res_reg;

    always_comb begin
        a_next = a_reg; x_next = x_reg; y_next = y_reg;
        sp_next = sp_reg; p_next = p_reg;
        r0 = '0;
        r0.new_pc = q_op.npc;
        wd1 = '0; wd2 = '0;
        ci = p_reg[0];
        v  = q_op.on_acc ? a_reg : q_op.m;
        rr = '0;
        am = (q_op.func == F_SBC) ? ~q_op.m : q_op.m;
        sum = {1'b0, a_reg} + {1'b0, am} + {8'd0, ci};
        case (q_op.func)
            F_ADC, F_SBC: begin
                a_next = sum[7:0]; p_next[0] = sum[8];
                p_next[6] = (a_reg[7] ^ sum[7]) & (am[7] ^ sum[7]);
                p_next[1] = (sum[7:0] == 8'd0); p_next[7] = sum[7];
            end
            F_AND: begin a_next = a_reg & q_op.m; end
            F_ORA: begin a_next = a_reg | q_op.m; end
            F_EOR: begin a_next = a_reg ^ q_op.m; end
            F_ASL, F_LSR, F_ROL, F_ROR: begin
                case (q_op.func)
                    F_ASL: begin p_next[0] = v[7]; rr = {v[6:0], 1'b0}; end
                    F_LSR: begin p_next[0] = v[0]; rr = {1'b0, v[7:1]}; end
                    F_ROL: begin p_next[0] = v[7]; rr = {v[6:0], ci}; end
                    default: begin p_next[0] = v[0]; rr = {ci, v[7:1]}; end
                endcase
                p_next[1] = (rr == 8'd0); p_next[7] = rr[7];
                if (q_op.on_acc) a_next = rr;
                else begin
                    r0.mem_write = 1'b1; r0.write_address = q_op.ea; r0.write_data = rr;
                end
            end
            F_BCC: if (!p_reg[0]) r0.new_pc = q_op.target;
            F_BCS: if (p_reg[0])  r0.new_pc = q_op.target;
            F_BEQ: if (p_reg[1])  r0.new_pc = q_op.target;
            F_BNE: if (!p_reg[1]) r0.new_pc = q_op.target;
            F_BMI: if (p_reg[7])  r0.new_pc = q_op.target;
            F_BPL: if (!p_reg[7]) r0.new_pc = q_op.target;
            F_BVS: if (p_reg[6])  r0.new_pc = q_op.target;
            F_BVC: if (!p_reg[6]) r0.new_pc = q_op.target;
            F_BIT: begin
                p_next[1] = ((a_reg & q_op.m) == 8'd0);
                p_next[7] = q_op.m[7]; p_next[6] = q_op.m[6];
            end
            F_BRK: begin
                r0.new_pc = q_op.npc + 16'd1;
                r0.mem_write = 1'b1; r0.write_address = {8'h01, sp_reg};
                r0.write_data = r0.new_pc[15:8];
                wd1 = r0.new_pc[7:0];
                wd2 = p_reg | 8'h30;
                sp_next = sp_reg - 8'd3;
                p_next[2] = 1'b1;
            end
            F_CLC: p_next[0] = 1'b0;
            F_CLD: p_next[3] = 1'b0;
            F_CLI: p_next[2] = 1'b0;
            F_CLV: p_next[6] = 1'b0;
            F_SEC: p_next[0] = 1'b1;
            F_SED: p_next[3] = 1'b1;
            F_SEI: p_next[2] = 1'b1;
            F_CMP, F_CPX, F_CPY: begin
                if (q_op.func == F_CMP) v = a_reg;
                else if (q_op.func == F_CPX) v = x_reg;
                else v = y_reg;
                p_next[0] = (v >= q_op.m);
                rr = v - q_op.m;
                p_next[1] = (rr == 8'd0); p_next[7] = rr[7];
            end
            F_DEC, F_INC: begin
                rr = (q_op.func == F_DEC) ? q_op.m - 8'd1 : q_op.m + 8'd1;
                p_next[1] = (rr == 8'd0); p_next[7] = rr[7];
                r0.mem_write = 1'b1; r0.write_address = q_op.ea; r0.write_data = rr;
            end
            F_DEX: x_next = x_reg - 8'd1;
            F_INX: x_next = x_reg + 8'd1;
            F_DEY: y_next = y_reg - 8'd1;
            F_INY: y_next = y_reg + 8'd1;
            F_JMP: r0.new_pc = q_op.ea;
            F_JSR: begin
                rr = '0;
                r0.new_pc = q_op.ea;
                r0.mem_write = 1'b1; r0.write_address = {8'h01, sp_reg};
                {r0.write_data, wd1} = q_op.npc - 16'd1;
                sp_next = sp_reg - 8'd2;
            end
            F_LDA: a_next = q_op.m;
            F_LDX: x_next = q_op.m;
            F_LDY: y_next = q_op.m;
            F_PHA, F_PHP: begin
                r0.mem_write = 1'b1; r0.write_address = {8'h01, sp_reg};
                r0.write_data = (q_op.func == F_PHA) ? a_reg : (p_reg | 8'h30);
                sp_next = sp_reg - 8'd1;
            end
            F_PLA: begin sp_next = sp_reg + 8'd1; a_next = q_op.s1; end
            F_PLP: begin
                sp_next = sp_reg + 8'd1;
                p_next = (q_op.s1 & 8'hCF) | (p_reg & 8'h30);
            end
            F_RTI: begin
                sp_next = sp_reg + 8'd3;
                p_next = (q_op.s1 & 8'hCF) | (p_reg & 8'h30);
                r0.new_pc = {q_op.s3, q_op.s2};
            end
            F_RTS: begin
                sp_next = sp_reg + 8'd2;
                r0.new_pc = {q_op.s2, q_op.s1} + 16'd1;
            end
            F_STA, F_STX, F_STY: begin
                r0.mem_write = 1'b1; r0.write_address = q_op.ea;
                r0.write_data = (q_op.func == F_STA) ? a_reg :
                                (q_op.func == F_STX) ? x_reg : y_reg;
            end
            F_TAX: x_next = a_reg;
            F_TAY: y_next = a_reg;
            F_TSX: x_next = sp_reg;
            F_TXA: a_next = x_reg;
            F_TXS: sp_next = x_reg;
            F_TYA: a_next = y_reg;
            default: ;
        endcase
        // Z/N from the register that the op loads
        case (q_op.func)
            F_AND, F_ORA, F_EOR, F_LDA, F_PLA, F_TXA, F_TYA: begin
                p_next[1] = (a_next == 8'd0); p_next[7] = a_next[7];
            end
            F_DEX, F_INX, F_LDX, F_TAX, F_TSX: begin
                p_next[1] = (x_next == 8'd0); p_next[7] = x_next[7];
            end
            F_DEY, F_INY, F_LDY, F_TAY: begin
                p_next[1] = (y_next == 8'd0); p_next[7] = y_next[7];
            end
            default: ;
        endcase
        r0.flags_out = p_next;
        r0.last = (q_op.nwr == 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg <= '0; x_reg <= '0; y_reg <= '0;
            sp_reg <= SP_RESET; p_reg <= P_RESET;
            k_reg <= '0; ov_reg <= 1'b0;
        end else if (can_out) begin
            ov_reg <= 1'b0;
            if (busy) begin
                ov_reg <= 1'b1;
                ov_res_reg.mem_write     <= 1'b1;
                ov_res_reg.write_address <= {8'h01, sp_reg + {6'd0, k_reg}};
                ov_res_reg.write_data    <= (k_reg == 2'd1) ? wd1_reg : wd2_reg;
                ov_res_reg.new_pc        <= pc_hold_reg;
                ov_res_reg.flags_out     <= p_hold_reg;
                ov_res_reg.last          <= (k_reg == 2'd1);
                k_reg <= k_reg - 2'd1;
            end else if (q_valid) begin
                ov_reg <= 1'b1;
                ov_res_reg <= r0;
                a_reg <= a_next; x_reg <= x_next; y_reg <= y_next;
                sp_reg <= sp_next; p_reg <= p_next;
                k_reg <= q_op.nwr;
                // pending pushes: index counts down, address is sp_next+k
                if (q_op.nwr == 2'd2) begin wd1_reg <= wd2; wd2_reg <= wd1; end
                else begin wd1_reg <= wd1; wd2_reg <= wd2; end
                pc_hold_reg <= r0.new_pc;
                p_hold_reg  <= p_next;
            end
        end
    end
endmodule

FILE: sv/m65_checker.sv
`timescale 1ns / 1ps
module m65_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast
);
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed under stall");
    a_nowr_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tlast)
        else $error("non-write result not last");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("valid after reset");
    a_nlast_stack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[16:9] == 8'h01)
        else $error("pending push not on stack page");
endmodule

bind mos6502_execute_unit m65_checker u_m65_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
